FILE: design/weighted_5x5_stencil_filter_top_defines.svh
// Assertion macros of the weighted 5x5 stencil filter, used by its top-level design file.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WEIGHTED_5X5_STENCIL_FILTER_TOP_DEFINES_SVH
`define WEIGHTED_5X5_STENCIL_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define W5S_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("w5s assertion failed");

// Next-cycle implication, checked outside reset.
`define W5S_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("w5s assertion failed");

`endif

FILE: design/w5s_pkg.sv
// Package of the weighted 5x5 stencil filter: widths, types and register codes.
// Depends on nothing; used by every module of the block but the line store memory.
`timescale 1ns / 1ps

package w5s_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 23;
    localparam int ROW_W       = 16;
    localparam int CCOL_W      = 10;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int WIN         = 5;
    localparam int LINES       = WIN - 1;
    localparam int MARGIN      = 2;
    localparam int PSUM_W      = SAMPLE_W + 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int FIFO_CW     = 4;

    typedef logic [SAMPLE_W-1:0]       sample_t;
    typedef logic [LINES*SAMPLE_W-1:0] line_col_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Control that travels with an item through the pipeline.
    typedef struct packed {
        logic              emit;
        logic              eof;
        logic [ROW_W-1:0]  center_row;
        logic [CCOL_W-1:0] center_col;
    } tag_t;

    typedef struct packed {
        logic [SUM_W-1:0]  weighted_sum;
        logic [ROW_W-1:0]  center_row;
        logic [CCOL_W-1:0] center_col;
        logic              end_of_frame;
    } result_t;

endpackage

FILE: design/w5s_line_mem.sv
// Line store memory: four packed lines per column, one read and one write port.
// Depends on nothing; same-edge write to the address being read is forwarded.
`timescale 1ns / 1ps

module w5s_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] ram_q_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            ram_q_reg    <= ram_reg[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // The array returns the old word when a write lands on the same edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : ram_q_reg;

endmodule

FILE: design/w5s_window.sv
// 5x5 window registers and the two-stage weighted adder tree.
// Depends on w5s_pkg.
`timescale 1ns / 1ps

module w5s_window (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  w5s_pkg::line_col_t       in_col,
    input  w5s_pkg::sample_t         in_px,
    input  w5s_pkg::tag_t            in_tag,
    output logic                     done_valid,
    output w5s_pkg::tag_t            done_tag,
    output logic [w5s_pkg::SUM_W-1:0] done_sum
);

    localparam int CROSS_W  = w5s_pkg::PSUM_W + 3;
    localparam int CENTER_W = w5s_pkg::SAMPLE_W + 4;

    w5s_pkg::sample_t win_reg [w5s_pkg::WIN][w5s_pkg::WIN];
    logic             w_valid_reg;
    w5s_pkg::tag_t    w_tag_reg;

    logic                        p_valid_reg;
    w5s_pkg::tag_t               p_tag_reg;
    logic [w5s_pkg::PSUM_W-1:0]  p_corner_reg;
    logic [w5s_pkg::PSUM_W-1:0]  p_edge_reg [3];
    logic [w5s_pkg::PSUM_W-1:0]  p_diag_reg;
    logic [CROSS_W-1:0]          p_cross5_reg;
    logic [CENTER_W-1:0]         p_center10_reg;

    logic [w5s_pkg::PSUM_W-1:0]  cross_sum;

    function automatic logic [w5s_pkg::PSUM_W-1:0] sum4(
        input w5s_pkg::sample_t a,
        input w5s_pkg::sample_t b,
        input w5s_pkg::sample_t c,
        input w5s_pkg::sample_t d
    );
        return w5s_pkg::PSUM_W'(a) + w5s_pkg::PSUM_W'(b)
             + w5s_pkg::PSUM_W'(c) + w5s_pkg::PSUM_W'(d);
    endfunction

    // Shift left and load the new column, oldest line on top.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            for (int i = 0; i < w5s_pkg::WIN; i++) begin
                for (int j = 0; j < w5s_pkg::WIN - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
            end
            for (int i = 0; i < w5s_pkg::LINES; i++) begin
                win_reg[i][w5s_pkg::WIN-1] <= in_col[i*w5s_pkg::SAMPLE_W +: w5s_pkg::SAMPLE_W];
            end
            win_reg[w5s_pkg::WIN-1][w5s_pkg::WIN-1] <= in_px;
        end
    end

    assign cross_sum = sum4(win_reg[1][2], win_reg[2][1], win_reg[2][3], win_reg[3][2]);

    // Group the symmetric kernel by weight: 1, 2, 4, 5 and 10.
    always_ff @(posedge aclk) begin
        w_tag_reg      <= in_tag;
        p_tag_reg      <= w_tag_reg;
        p_corner_reg   <= sum4(win_reg[0][0], win_reg[0][4], win_reg[4][0], win_reg[4][4]);
        p_edge_reg[0]  <= sum4(win_reg[0][1], win_reg[0][2], win_reg[0][3], win_reg[1][0]);
        p_edge_reg[1]  <= sum4(win_reg[4][1], win_reg[4][2], win_reg[4][3], win_reg[1][4]);
        p_edge_reg[2]  <= sum4(win_reg[2][0], win_reg[3][0], win_reg[2][4], win_reg[3][4]);
        p_diag_reg     <= sum4(win_reg[1][1], win_reg[1][3], win_reg[3][1], win_reg[3][3]);
        p_cross5_reg   <= (CROSS_W'(cross_sum) << 2) + CROSS_W'(cross_sum);
        p_center10_reg <= (CENTER_W'(win_reg[2][2]) << 3) + (CENTER_W'(win_reg[2][2]) << 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            w_valid_reg <= in_valid;
            p_valid_reg <= w_valid_reg;
        end
    end

    always_comb begin
        done_sum = w5s_pkg::SUM_W'(p_corner_reg)
                 + ((w5s_pkg::SUM_W'(p_edge_reg[0]) + w5s_pkg::SUM_W'(p_edge_reg[1])
                   + w5s_pkg::SUM_W'(p_edge_reg[2])) << 1)
                 + (w5s_pkg::SUM_W'(p_diag_reg) << 2)
                 + w5s_pkg::SUM_W'(p_cross5_reg)
                 + w5s_pkg::SUM_W'(p_center10_reg);
    end

    assign done_valid = p_valid_reg;
    assign done_tag   = p_tag_reg;

endmodule

FILE: design/w5s_out_fifo.sv
// Result queue between the adder tree and the output channel.
// Depends on w5s_pkg.
`timescale 1ns / 1ps

module w5s_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  w5s_pkg::result_t              push_data,
    input  logic                          pop,
    output logic                          out_valid,
    output w5s_pkg::result_t              out_data,
    output logic [w5s_pkg::FIFO_CW-1:0]   count
);

    w5s_pkg::result_t                 slot_reg [w5s_pkg::FIFO_DEPTH];
    logic [w5s_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [w5s_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [w5s_pkg::FIFO_CW-1:0]      count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + w5s_pkg::FIFO_CW'(push) - w5s_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: design/weighted_5x5_stencil_filter_top.sv
// Weighted 5x5 stencil filter, top level: handshakes, raster counters, line store, window.
// Depends on w5s_pkg, w5s_line_mem, w5s_window, w5s_out_fifo and the defines header.
// Throughput: one pixel per clock while s_ready is high, set by the single read and
// write port of the line store. Reset (aresetn low at a clock edge) clears counters,
// queue and pipeline valid bits and loads image_width 640 and image_height 480; line
// store and window keep their contents.
`timescale 1ns / 1ps
`include "weighted_5x5_stencil_filter_top_defines.svh"

module weighted_5x5_stencil_filter_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [w5s_pkg::SAMPLE_W-1:0]      s_pixel_in,
    input  logic                              s_start_of_frame,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [w5s_pkg::SUM_W-1:0]         m_weighted_sum,
    output logic [w5s_pkg::ROW_W-1:0]         m_center_row,
    output logic [w5s_pkg::CCOL_W-1:0]        m_center_col,
    output logic                              m_end_of_frame,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [w5s_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [w5s_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Column counter and line store address width.
    localparam int CW = $clog2(MAX_WIDTH);
    // Width of the effective line length, wide enough for the register and MAX_WIDTH.
    localparam int WW = ($clog2(MAX_WIDTH + 1) > w5s_pkg::CFG_WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : w5s_pkg::CFG_WIDTH_W;
    localparam int RW = w5s_pkg::ROW_W;

    // Configuration registers.
    logic [w5s_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [RW-1:0]                   height_reg;

    // Raster position of the next pixel.
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;

    // Stage one: the pixel whose line store column is being read.
    logic                s1_valid_reg;
    logic [CW-1:0]       s1_col_reg;
    w5s_pkg::sample_t    s1_px_reg;
    w5s_pkg::tag_t       s1_tag_reg;

    // Transactions accepted whose result has not yet left or been dropped.
    logic [w5s_pkg::FIFO_CW-1:0] pending_reg, pending_next;

    logic                s_accept;
    logic                m_pop;
    logic [CW-1:0]       col_cur;
    logic [RW-1:0]       row_cur;
    logic [WW-1:0]       w_eff;
    logic [WW:0]         col_p1;
    logic [RW:0]         row_p1;
    logic                col_wrap;
    logic [CW-1:0]       col_m2;
    w5s_pkg::tag_t       tag_cur;

    w5s_pkg::line_col_t  rd_col;
    w5s_pkg::line_col_t  wr_col;

    logic                done_valid;
    w5s_pkg::tag_t       done_tag;
    logic [w5s_pkg::SUM_W-1:0] done_sum;
    logic                fifo_push;
    logic                drop;
    w5s_pkg::result_t    fifo_in;
    w5s_pkg::result_t    fifo_out;
    logic [w5s_pkg::FIFO_CW-1:0] fifo_count;

    // ------------------------------------------------------------------
    // Configuration. The port never stalls; the user keeps writes to idle, unenforced.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= w5s_pkg::CFG_WIDTH_W'(640);
            height_reg <= RW'(480);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                w5s_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[w5s_pkg::CFG_WIDTH_W-1:0];
                end
                w5s_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Every accepted transaction holds one credit until its
    // result is popped, or until it leaves the adder tree as a border pixel.
    // With as many credits as queue slots, the queue can never overflow, so
    // the pipeline in front of it never stalls.
    // ------------------------------------------------------------------
    assign s_ready  = (pending_reg < w5s_pkg::FIFO_CW'(w5s_pkg::FIFO_DEPTH));
    assign s_accept = s_valid && s_ready;
    assign m_pop    = m_valid && m_ready;

    assign fifo_push = done_valid && done_tag.emit;
    assign drop      = done_valid && !done_tag.emit;

    always_comb begin
        pending_next = pending_reg + w5s_pkg::FIFO_CW'(s_accept)
                     - w5s_pkg::FIFO_CW'(m_pop) - w5s_pkg::FIFO_CW'(drop);
    end

    // ------------------------------------------------------------------
    // Raster position. A start-of-frame mark puts the pixel at the origin.
    // The line length is clipped to MAX_WIDTH; lengths of zero act as one.
    // ------------------------------------------------------------------
    always_comb begin
        col_cur = s_start_of_frame ? '0 : col_reg;
        row_cur = s_start_of_frame ? '0 : row_reg;

        if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end

        col_p1   = (WW + 1)'(col_cur) + 1'b1;
        row_p1   = (RW + 1)'(row_cur) + 1'b1;
        col_wrap = (col_p1 >= (WW + 1)'(w_eff));

        if (col_wrap) begin
            col_next = '0;
            row_next = (row_p1 >= (RW + 1)'(height_reg)) ? '0 : RW'(row_p1);
        end else begin
            col_next = CW'(col_p1);
            row_next = row_cur;
        end

        // Interior pixels: the whole window, four lines and four columns
        // back, lies inside the image.
        col_m2             = col_cur - CW'(w5s_pkg::MARGIN);
        tag_cur.emit       = (row_cur >= RW'(w5s_pkg::LINES))
                          && ((WW + 1)'(col_cur) >= (WW + 1)'(w5s_pkg::LINES))
                          && ((RW + 1)'(row_cur) < (RW + 1)'(height_reg))
                          && ((WW + 1)'(col_cur) < (WW + 1)'(w_eff));
        tag_cur.eof        = (row_p1 == (RW + 1)'(height_reg))
                          && (col_p1 == (WW + 1)'(w_eff));
        tag_cur.center_row = row_cur - RW'(w5s_pkg::MARGIN);
        tag_cur.center_col = w5s_pkg::CCOL_W'(col_m2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            pending_reg  <= '0;
        end else begin
            if (s_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= s_accept;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_col_reg <= col_cur;
            s1_px_reg  <= s_pixel_in;
            s1_tag_reg <= tag_cur;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The read is issued on the accepting edge; in stage one
    // the column comes back, feeds the window, and is written back aged by
    // one line with the new pixel as the youngest line.
    // ------------------------------------------------------------------
    assign wr_col = {s1_px_reg, rd_col[w5s_pkg::LINES*w5s_pkg::SAMPLE_W-1:w5s_pkg::SAMPLE_W]};

    w5s_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (w5s_pkg::LINES * w5s_pkg::SAMPLE_W)
    ) u_line_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (rd_col),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_col)
    );

    // Window shift and weighted sum over two register stages.
    w5s_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s1_valid_reg),
        .in_col     (rd_col),
        .in_px      (s1_px_reg),
        .in_tag     (s1_tag_reg),
        .done_valid (done_valid),
        .done_tag   (done_tag),
        .done_sum   (done_sum)
    );

    // Interior results are queued; border pixels end here.
    always_comb begin
        fifo_in.weighted_sum = done_sum;
        fifo_in.center_row   = done_tag.center_row;
        fifo_in.center_col   = done_tag.center_col;
        fifo_in.end_of_frame = done_tag.eof;
    end

    w5s_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (fifo_in),
        .pop       (m_pop),
        .out_valid (m_valid),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_weighted_sum = fifo_out.weighted_sum;
    assign m_center_row   = fifo_out.center_row;
    assign m_center_col   = fifo_out.center_col;
    assign m_end_of_frame = fifo_out.end_of_frame;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `W5S_ASSERT_NOW(a_credit_bound, aclk, aresetn, 1'b1,
        pending_reg <= w5s_pkg::FIFO_CW'(w5s_pkg::FIFO_DEPTH))
    `W5S_ASSERT_NOW(a_queue_covered, aclk, aresetn, 1'b1, fifo_count <= pending_reg)
    `W5S_ASSERT_NOW(a_col_in_store, aclk, aresetn, 1'b1, int'(col_reg) < MAX_WIDTH)
    `W5S_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_accept, s1_valid_reg)

endmodule

FILE: tb/weighted_5x5_stencil_filter_top_test.sv
// Testbench for the weighted 5x5 stencil filter: a pixel stream driver, a result sink
// and a scoreboard that predicts every windowed sum. Depends on w5s_pkg and on the
// weighted_5x5_stencil_filter_top RTL.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the registers, line stores, window and raster
// counters, and keeps the results that the accepted pixels should produce, in order.
class stencil_scoreboard;
    localparam int unsigned LINE_MAX = 1024;

    int unsigned width_reg;
    int unsigned height_reg;
    bit [15:0]   line_mem [4][LINE_MAX];
    bit [15:0]   win [5][5];
    int unsigned col_pos;
    int unsigned row_pos;
    w5s_pkg::result_t expected_q [$];
    int unsigned errors;
    int unsigned printed;
    int unsigned pixels;
    int unsigned results;

    function new();
        width_reg  = 640;
        height_reg = 480;
        col_pos    = 0;
        row_pos    = 0;
        errors     = 0;
        printed    = 0;
        pixels     = 0;
        results    = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void set_reg(w5s_pkg::cfg_reg_t idx, logic [15:0] data);
        case (idx)
            w5s_pkg::CFG_IMAGE_WIDTH: begin
                width_reg = data[10:0];
            end
            w5s_pkg::CFG_IMAGE_HEIGHT: begin
                height_reg = data;
            end
            default: begin
            end
        endcase
    endfunction

    // Kernel weight, ten times the filter tap, by distance from the window center.
    function int unsigned tap_weight(int i, int j);
        int di;
        int dj;
        di = (i > 2) ? i - 2 : 2 - i;
        dj = (j > 2) ? j - 2 : 2 - j;
        if (di == 2 && dj == 2)
            return 1;
        if (di == 2 || dj == 2)
            return 2;
        if (di == 1 && dj == 1)
            return 4;
        if (di + dj == 1)
            return 5;
        return 10;
    endfunction

    function void note_pixel(w5s_pkg::sample_t px, bit sof);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      idx;
        bit [63:0]        acc;
        w5s_pkg::result_t res;
        w = (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
        h = height_reg;
        c = col_pos;
        r = row_pos;
        if (sof) begin
            c = 0;
            r = 0;
        end
        idx = c % LINE_MAX;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                win[i][j] = win[i][j+1];
        for (int i = 0; i < 4; i++)
            win[i][4] = line_mem[i][idx];
        win[4][4] = px;
        for (int i = 0; i < 3; i++)
            line_mem[i][idx] = line_mem[i+1][idx];
        line_mem[3][idx] = px;
        if (r >= 4 && c >= 4 && r < h && c < w) begin
            acc = 0;
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    acc += 64'(tap_weight(i, j)) * 64'(win[i][j]);
            res.weighted_sum = acc[22:0];
            res.center_row   = 16'(r - 2);
            res.center_col   = 10'(c - 2);
            res.end_of_frame = (r + 1 == h) && (c + 1 == w);
            expected_q.push_back(res);
        end
        if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
        col_pos = c;
        row_pos = r & 32'hFFFF;
        pixels++;
    endfunction

    task report(string msg);
        errors++;
        if (printed < 100) begin
            printed++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    task check_result(w5s_pkg::result_t got);
        w5s_pkg::result_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result sum=%0d row=%0d col=%0d eof=%0b",
                             got.weighted_sum, got.center_row, got.center_col,
                             got.end_of_frame));
            return;
        end
        want = expected_q.pop_front();
        results++;
        if (got.weighted_sum !== want.weighted_sum)
            report($sformatf("weighted_sum at (%0d,%0d): got %0d, want %0d",
                             want.center_row, want.center_col,
                             got.weighted_sum, want.weighted_sum));
        if (got.center_row !== want.center_row)
            report($sformatf("center_row: got %0d, want %0d",
                             got.center_row, want.center_row));
        if (got.center_col !== want.center_col)
            report($sformatf("center_col at row %0d: got %0d, want %0d",
                             want.center_row, got.center_col, want.center_col));
        if (got.end_of_frame !== want.end_of_frame)
            report($sformatf("end_of_frame at (%0d,%0d): got %0b, want %0b",
                             want.center_row, want.center_col,
                             got.end_of_frame, want.end_of_frame));
    endtask

    task flush_missing();
        report($sformatf("%0d expected results never arrived", expected_q.size()));
        expected_q.delete();
    endtask
endclass

module weighted_5x5_stencil_filter_top_test;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 700_000;
    localparam int RANDOM_ITEMS = 470;
    // Cycles to let the pipeline empty after the last expected result, since pixels
    // that give no result may still be in flight.
    localparam int SETTLE       = 8;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [w5s_pkg::SAMPLE_W-1:0]    s_pixel_in;
    logic                            s_start_of_frame;
    logic                            m_valid;
    logic                            m_ready;
    logic [w5s_pkg::SUM_W-1:0]       m_weighted_sum;
    logic [w5s_pkg::ROW_W-1:0]       m_center_row;
    logic [w5s_pkg::CCOL_W-1:0]      m_center_col;
    logic                            m_end_of_frame;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [w5s_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [w5s_pkg::CFG_DATA_W-1:0]  cfg_data;

    stencil_scoreboard board = new();

    // Idling switches for the two sides; turned off now and then so that long
    // back-to-back stretches occur as well.
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int unsigned random_items = 0;
    int unsigned cfg_writes = 0;
    int unsigned settings = 0;

    weighted_5x5_stencil_filter_top #(
        .MAX_WIDTH(1024)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_in      (s_pixel_in),
        .s_start_of_frame(s_start_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_weighted_sum  (m_weighted_sum),
        .m_center_row    (m_center_row),
        .m_center_col    (m_center_col),
        .m_end_of_frame  (m_end_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // All driving happens at the falling edge; transactions are recognized at the
    // rising edge, where the handshake signals are stable.

    // Sends one pixel. The caller is at a falling edge, and so is this task when it
    // returns; valid stays high so that the next pixel can follow without a gap.
    task send_pixel(w5s_pkg::sample_t px, bit sof);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_pixel_in       = px;
        s_start_of_frame = sof;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_pixel(px, sof);
        @(negedge aclk);
    endtask

    // A register write is one transaction on the configuration channel. It is only
    // issued while the pixel channel is quiet and every result has come back.
    task write_reg(w5s_pkg::cfg_reg_t idx, logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        board.set_reg(idx, data);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task set_image(logic [15:0] w, logic [15:0] h);
        drain_results();
        write_reg(w5s_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(w5s_pkg::CFG_IMAGE_HEIGHT, h);
        settings++;
    endtask

    // Holds the pixel channel idle until every predicted result has arrived, then
    // lets the pipeline settle. A bounded wait turns lost results into a failure.
    task drain_results();
        int unsigned waited;
        s_valid = 1'b0;
        waited  = 0;
        while (board.pending() != 0 && waited < 4000) begin
            @(negedge aclk);
            waited++;
        end
        if (board.pending() != 0)
            board.flush_missing();
        repeat (SETTLE) @(negedge aclk);
    endtask

    function w5s_pkg::sample_t random_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'h0000;
        if (sel == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task send_run(int unsigned count, bit sof_first);
        for (int unsigned k = 0; k < count; k++)
            send_pixel(random_sample(), sof_first && k == 0);
    endtask

    // One random setting: a small image, then one to three frames. Most frames are
    // complete; some are cut short, some later ones rely on the counters wrapping
    // instead of a start mark, and a stray start mark now and then restarts a frame.
    // The first frame always carries a start mark, since a wider image must not read
    // line store columns that the previous, narrower setting never filled.
    task run_random_setting();
        int unsigned w;
        int unsigned h;
        int unsigned sel;
        int unsigned frames;
        int unsigned full;
        int unsigned n;
        bit          sof;
        bit          broken;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            w = $urandom_range(5, 12);
        else if (sel == 8)
            w = $urandom_range(0, 4);
        else
            w = $urandom_range(13, 40);
        h = ($urandom_range(0, 9) < 8) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        // Bits above the 11-bit width register are sometimes set; they are dropped.
        if ($urandom_range(0, 3) == 0)
            set_image((16'($urandom) & 16'hF800) | 16'(w), 16'(h));
        else
            set_image(16'(w), 16'(h));
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        frames    = $urandom_range(1, 3);
        full      = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        broken    = 1'b1;
        for (int unsigned f = 0; f < frames; f++) begin
            n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, full) : full;
            for (int unsigned k = 0; k < n; k++) begin
                if (k == 0)
                    sof = broken || ($urandom_range(0, 2) != 0);
                else
                    sof = ($urandom_range(0, 49) == 0);
                send_pixel(random_sample(), sof);
                random_items++;
                // Occasionally hold the stream until the block has caught up.
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
            broken = (n != full);
        end
    endtask

    // Result sink: draws a stall for each transaction, then waits with ready high.
    initial begin : result_sink
        int unsigned      stall;
        w5s_pkg::result_t got;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = recv_idle ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.weighted_sum = m_weighted_sum;
            got.center_row   = m_center_row;
            got.center_col   = m_center_col;
            got.end_of_frame = m_end_of_frame;
            board.check_result(got);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_pixel_in       = '0;
        s_start_of_frame = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = w5s_pkg::CFG_IMAGE_WIDTH;
        cfg_data         = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The reset image size of 640 x 480: the first lines hold no interior pixel,
        // so a short run must give no result at all.
        send_run(40, 1'b1);

        // Smallest image: one frame of full-scale samples gives the largest sum and
        // the end mark; the next frame of zeros follows by counter wrap alone.
        set_image(16'd5, 16'd5);
        for (int k = 0; k < 25; k++)
            send_pixel(16'hFFFF, k == 0);
        for (int k = 0; k < 25; k++)
            send_pixel(16'h0000, 1'b0);

        // Shrink both dimensions in the middle of a frame: the counters carry on and
        // the rows already stored are reused.
        set_image(16'd6, 16'd9);
        send_run(30, 1'b1);
        set_image(16'd5, 16'd7);
        send_run(10, 1'b0);

        // Sizes below the window: no results, but the counters still wrap. Zero
        // sizes hold the column counter at the start of the line.
        set_image(16'd3, 16'd7);
        send_run(30, 1'b1);
        set_image(16'd0, 16'd0);
        send_run(6, 1'b1);
        set_image(16'd1, 16'd4);
        send_run(6, 1'b1);
        set_image(16'd8, 16'd2);
        send_run(20, 1'b1);
        set_image(16'd4, 16'hFFFF);
        send_run(8, 1'b1);

        // Widest line, and a width register above the line store size that acts as
        // the widest line: the start of the first line gives no result.
        set_image(16'd1024, 16'd5);
        send_run(40, 1'b1);
        set_image(16'd2047, 16'd6);
        send_run(40, 1'b1);

        while (random_items < RANDOM_ITEMS)
            run_random_setting();

        drain_results();
        $display("Run covered %0d pixels, %0d checked results, %0d image settings",
                 board.pixels, board.results, settings);
        $display("and %0d register writes, %0d random pixels among them.",
                 cfg_writes, random_items);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hang: several times the slowest correct run.
    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule
